### rtl/llkc_pkg.sv
// ----------------------------------------------------------------------------
// llkc_pkg: shared constants for the log line keyword classifier
// window sizes, keyword table and the ascii case fold
// ----------------------------------------------------------------------------
`default_nettype none

package llkc_pkg;

  localparam int WINDOW_BYTES   = 19;
  localparam int CATEGORY_COUNT = 8;
  localparam int HIST_DEPTH     = WINDOW_BYTES - 1;
  localparam int FILL_W         = $clog2(HIST_DEPTH + 1);
  localparam int LEN_W          = $clog2(WINDOW_BYTES + 1);
  localparam int CAT_W          = $clog2(CATEGORY_COUNT);
  localparam int KW_COUNT       = 26;

  typedef logic [7:0]                    byte_t;
  typedef logic [HIST_DEPTH-1:0][7:0]    hist_t;
  typedef logic [WINDOW_BYTES-1:0][7:0]  window_t;
  typedef logic [CATEGORY_COUNT-1:0]     cat_mask_t;
  typedef logic [FILL_W-1:0]             fill_t;

  // keyword text is right justified: byte 0 is the last character
  typedef struct packed {
    window_t          text;
    logic [LEN_W-1:0] len;
    logic [CAT_W-1:0] cat;
  } kw_entry_t;

  localparam kw_entry_t KW_TABLE [KW_COUNT] = '{
    '{window_t'("startup finished in"), LEN_W'(19), CAT_W'(0)},
    '{window_t'("reached target"),      LEN_W'(14), CAT_W'(0)},
    '{window_t'("failed"),              LEN_W'(6),  CAT_W'(1)},
    '{window_t'("warn"),                LEN_W'(4),  CAT_W'(2)},
    '{window_t'("error"),               LEN_W'(5),  CAT_W'(3)},
    '{window_t'("critical"),            LEN_W'(8),  CAT_W'(3)},
    '{window_t'("usb"),                 LEN_W'(3),  CAT_W'(4)},
    '{window_t'("pci"),                 LEN_W'(3),  CAT_W'(4)},
    '{window_t'("sda"),                 LEN_W'(3),  CAT_W'(4)},
    '{window_t'("nvme"),                LEN_W'(4),  CAT_W'(4)},
    '{window_t'("driver"),              LEN_W'(6),  CAT_W'(4)},
    '{window_t'("firmware"),            LEN_W'(8),  CAT_W'(4)},
    '{window_t'("network"),             LEN_W'(7),  CAT_W'(5)},
    '{window_t'("eth0"),                LEN_W'(4),  CAT_W'(5)},
    '{window_t'("wlan"),                LEN_W'(4),  CAT_W'(5)},
    '{window_t'("dhcp"),                LEN_W'(4),  CAT_W'(5)},
    '{window_t'("ip"),                  LEN_W'(2),  CAT_W'(5)},
    '{window_t'("sudo"),                LEN_W'(4),  CAT_W'(6)},
    '{window_t'("authentication"),      LEN_W'(14), CAT_W'(6)},
    '{window_t'("passwd"),              LEN_W'(6),  CAT_W'(6)},
    '{window_t'("login"),               LEN_W'(5),  CAT_W'(6)},
    '{window_t'("mount"),               LEN_W'(5),  CAT_W'(7)},
    '{window_t'("fsck"),                LEN_W'(4),  CAT_W'(7)},
    '{window_t'("ext4"),                LEN_W'(4),  CAT_W'(7)},
    '{window_t'("btrfs"),               LEN_W'(5),  CAT_W'(7)},
    '{window_t'("ntfs"),                LEN_W'(4),  CAT_W'(7)}
  };

  // fold ascii upper case only
  function automatic byte_t fold_lower(input byte_t c);
    byte_t r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5a) begin
      r = c + 8'h20;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/log_line_keyword_classifier.sv
// ----------------------------------------------------------------------------
// log_line_keyword_classifier: per-line keyword category mask
// scans log text a byte a cycle, unless a last byte is held back, and reports which keyword groups a line hit
// ----------------------------------------------------------------------------
// path: a line's last byte waits in the input register, and its mask is then
//   registered into the result register and driven on the output from there
// throughput: one byte per cycle; a last byte waits only while the previous
//   mask is still held on the output
// reset: asynchronous, active low; clears history, fill count, mask, nul flag
//   and both valid bits, the block takes a byte right after reset
`default_nettype none

module log_line_keyword_classifier import llkc_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output      logic in_ready_o,
  input  wire logic [7:0] text_byte_i,
  input  wire logic line_end_i,
  output      logic out_valid_o,
  input  wire logic out_ready_i,
  output      logic [7:0] category_mask_o
);

  // input register
  logic  s1_valid_q, s1_valid_d;
  byte_t s1_byte_q, s1_byte_d;
  logic  s1_last_q, s1_last_d;

  // line state
  hist_t     hist_q, hist_d;
  fill_t     fill_q, fill_d;
  cat_mask_t match_q, match_d;
  logic      nul_q, nul_d;

  // result register
  logic      out_valid_q, out_valid_d;
  cat_mask_t out_mask_q, out_mask_d;

  byte_t     folded;
  cat_mask_t hits;
  cat_mask_t match_new;
  logic      s1_adv;
  logic      in_fire;
  logic      take_byte;

  llkc_matcher u_matcher (
    .raw_byte_i (s1_byte_q),
    .history_i  (hist_q),
    .fill_i     (fill_q),
    .folded_o   (folded),
    .hits_o     (hits)
  );

  // a middle byte never waits; a last byte needs a free result slot
  assign s1_adv     = s1_valid_q && (!s1_last_q || !out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_fire    = in_valid_i && in_ready_o;

  // a zero byte stops matching and storing for the rest of the line
  assign take_byte = s1_adv && !nul_q && (s1_byte_q != 8'h00);
  assign match_new = take_byte ? (match_q | hits) : match_q;

  always_comb begin
    s1_valid_d  = s1_valid_q;
    s1_byte_d   = s1_byte_q;
    s1_last_d   = s1_last_q;
    hist_d      = hist_q;
    fill_d      = fill_q;
    match_d     = match_q;
    nul_d       = nul_q;
    out_valid_d = out_valid_q;
    out_mask_d  = out_mask_q;

    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end

    if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
    if (in_fire) begin
      s1_valid_d = 1'b1;
      s1_byte_d  = text_byte_i;
      s1_last_d  = line_end_i;
    end

    if (s1_adv && !nul_q && (s1_byte_q == 8'h00)) begin
      nul_d = 1'b1;
    end

    if (take_byte) begin
      // shift history, newest byte at index 0
      for (int i = HIST_DEPTH - 1; i > 0; i--) begin
        hist_d[i] = hist_q[i-1];
      end
      hist_d[0] = folded;
      if (int'(fill_q) < HIST_DEPTH) begin
        fill_d = fill_q + fill_t'(1);
      end
    end
    match_d = match_new;

    // last byte: emit mask and start the next line clean
    if (s1_adv && s1_last_q) begin
      out_valid_d = 1'b1;
      out_mask_d  = match_new;
      hist_d      = '0;
      fill_d      = '0;
      match_d     = '0;
      nul_d       = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      hist_q      <= '0;
      fill_q      <= '0;
      match_q     <= '0;
      nul_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      hist_q      <= hist_d;
      fill_q      <= fill_d;
      match_q     <= match_d;
      nul_q       <= nul_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    s1_byte_q  <= s1_byte_d;
    s1_last_q  <= s1_last_d;
    out_mask_q <= out_mask_d;
  end

  assign out_valid_o     = out_valid_q;
  assign category_mask_o = out_mask_q;

  // fill count saturates at the history depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(fill_q) <= HIST_DEPTH)
    else $error("history fill beyond depth");

  // a finished line leaves clean state behind
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && s1_last_q) |=> (fill_q == '0 && match_q == '0 && !nul_q))
    else $error("line state not cleared after last byte");

  // after a zero byte nothing more is stored in the line
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (nul_q && !(s1_adv && s1_last_q)) |=> ($stable(fill_q) && $stable(hist_q)))
    else $error("history changed after zero byte");

  // a held byte in the input register is not overwritten
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_adv) |=> (s1_valid_q && $stable(s1_byte_q) && $stable(s1_last_q)))
    else $error("stalled input register overwritten");

endmodule

`default_nettype wire

### rtl/llkc_matcher.sv
// ----------------------------------------------------------------------------
// llkc_matcher: parallel keyword compare
// folds the new byte and checks every keyword ending at it against the history
// ----------------------------------------------------------------------------
`default_nettype none

module llkc_matcher import llkc_pkg::*; (
  input  byte_t     raw_byte_i,
  input  hist_t     history_i,
  input  fill_t     fill_i,
  output byte_t     folded_o,
  output cat_mask_t hits_o
);

  byte_t   folded;
  window_t window;

  assign folded   = fold_lower(raw_byte_i);
  assign folded_o = folded;

  // window byte 0 is the new byte, byte j the one j places back
  always_comb begin
    window[0] = folded;
    for (int j = 1; j < WINDOW_BYTES; j++) begin
      window[j] = history_i[j-1];
    end
  end

  always_comb begin
    logic hit;
    hits_o = '0;
    for (int k = 0; k < KW_COUNT; k++) begin
      hit = (int'(fill_i) >= int'(KW_TABLE[k].len) - 1);
      for (int j = 0; j < WINDOW_BYTES; j++) begin
        if (j < int'(KW_TABLE[k].len) && window[j] != KW_TABLE[k].text[j]) begin
          hit = 1'b0;
        end
      end
      if (hit) begin
        hits_o[KW_TABLE[k].cat] = 1'b1;
      end
    end
  end

endmodule

`default_nettype wire
